FILE: src/sm3_hash_engine_core_defines.svh
// Assertion helpers for the SM3 hash engine.
`ifndef SM3_HASH_ENGINE_CORE_DEFINES_SVH
`define SM3_HASH_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SM3_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sm3 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SM3_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sm3 check failed");

`endif

FILE: src/sm3_pkg.sv
// ---------------------------------------------------------------------------
// SM3 package
// Item types, state encodings, constants and round helpers for the engine.
// ---------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_item_t;

  // One word of a block as it travels from front to back.
  typedef struct packed {
    logic [31:0] word;
    logic        fin;    // last word of the final block: emit digest after it
  } blk_word_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PAD2,
    F_ZERO,
    F_LENLO
  } front_state_e;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_FOLD,
    B_OUT
  } back_state_e;

  localparam logic [31:0] T_LOW    = 32'h79CC4519;
  localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
  localparam logic [31:0] PAD_WORD = 32'h80000000;

  localparam logic [7:0][31:0] IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

endpackage

`default_nettype wire

FILE: src/sm3_front.sv
// ---------------------------------------------------------------------------
// SM3 front end
// Takes message items, counts bits and generates padding and length words.
// ---------------------------------------------------------------------------
`default_nettype none

module sm3_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire sm3_pkg::in_item_t  item_i,
  output logic                    wr_en_o,
  output sm3_pkg::blk_word_t      wr_data_o,
  input  wire logic               q_full_i
);

  sm3_pkg::front_state_e st_q, st_d;
  logic [63:0] bits_q;
  logic [3:0]  fill_q;
  logic [2:0]  nb;
  logic [31:0] keep, mark;
  logic        accept;

  assign full_o = (st_q != sm3_pkg::F_IDLE) || q_full_i;
  assign accept = push_i && !full_o;

  // Byte count of this item; partial words only count with last.
  assign nb = (!item_i.is_last || item_i.valid_bytes > 3'd4) ? 3'd4 : item_i.valid_bytes;

  always_comb begin
    case (nb[1:0])
      2'd0:    begin keep = 32'h00000000; mark = 32'h80000000; end
      2'd1:    begin keep = 32'hFF000000; mark = 32'h00800000; end
      2'd2:    begin keep = 32'hFFFF0000; mark = 32'h00008000; end
      default: begin keep = 32'hFFFFFF00; mark = 32'h00000080; end
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sm3_pkg::F_IDLE: begin
        if (accept && item_i.is_last) begin
          st_d = (nb == 3'd4) ? sm3_pkg::F_PAD2 : sm3_pkg::F_ZERO;
        end
      end
      sm3_pkg::F_PAD2: begin
        if (!q_full_i) st_d = sm3_pkg::F_ZERO;
      end
      sm3_pkg::F_ZERO: begin
        if (!q_full_i && fill_q == 4'd14) st_d = sm3_pkg::F_LENLO;
      end
      sm3_pkg::F_LENLO: begin
        if (!q_full_i) st_d = sm3_pkg::F_IDLE;
      end
      default: st_d = sm3_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    wr_en_o   = 1'b0;
    wr_data_o = '{word: 32'h0, fin: 1'b0};
    unique case (st_q)
      sm3_pkg::F_IDLE: begin
        wr_en_o        = accept;
        wr_data_o.word = (nb == 3'd4) ? item_i.message_word
                                      : ((item_i.message_word & keep) | mark);
      end
      sm3_pkg::F_PAD2: begin
        wr_en_o        = !q_full_i;
        wr_data_o.word = sm3_pkg::PAD_WORD;
      end
      sm3_pkg::F_ZERO: begin
        wr_en_o        = !q_full_i;
        wr_data_o.word = (fill_q == 4'd14) ? bits_q[63:32] : 32'h0;
      end
      sm3_pkg::F_LENLO: begin
        wr_en_o   = !q_full_i;
        wr_data_o = '{word: bits_q[31:0], fin: 1'b1};
      end
      default: wr_en_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= sm3_pkg::F_IDLE;
      bits_q <= 64'h0;
      fill_q <= 4'h0;
    end else begin
      st_q <= st_d;
      if (wr_en_o) fill_q <= fill_q + 4'd1;
      if (accept) bits_q <= bits_q + {58'h0, nb, 3'b000};
      else if (st_q == sm3_pkg::F_LENLO && !q_full_i) bits_q <= 64'h0;
    end
  end

endmodule

`default_nettype wire

FILE: src/sm3_fifo.sv
// ---------------------------------------------------------------------------
// SM3 word queue
// Small queue of block words between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module sm3_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire sm3_pkg::blk_word_t  wr_data_i,
  output logic                     full_o,
  input  wire logic                rd_en_i,
  output sm3_pkg::blk_word_t       rd_data_o,
  output logic                     empty_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);

  sm3_pkg::blk_word_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == CW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == LastPtr) ? '0 : wp_q + AW'(1);
      if (do_rd) rp_q <= (rp_q == LastPtr) ? '0 : rp_q + AW'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + CW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: src/sm3_back.sv
// ---------------------------------------------------------------------------
// SM3 back end
// Collects 16-word blocks, runs 64 compression rounds, emits the digest.
// ---------------------------------------------------------------------------
`default_nettype none

module sm3_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sm3_pkg::blk_word_t  rd_data_i,
  input  wire logic                q_empty_i,
  output logic                     rd_en_o,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output sm3_pkg::out_item_t       item_o
);

  sm3_pkg::back_state_e st_q, st_d;
  logic [15:0][31:0] w_q;
  logic [7:0][31:0]  v_q, cv_q;
  logic [31:0]       t_q;
  logic [5:0]        cnt_q;
  logic              fin_q;
  logic              out_valid_q;
  sm3_pkg::out_item_t out_q;
  logic              out_load;

  // Round datapath; w_q[0] is W[j], the window holds W[j..j+15].
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic        low;

  assign low = (cnt_q < 6'd16);
  assign a12 = sm3_pkg::rotl(v_q[0], 12);
  assign ss1 = sm3_pkg::rotl(a12 + v_q[4] + t_q, 7);
  assign ss2 = ss1 ^ a12;
  assign ff  = low ? (v_q[0] ^ v_q[1] ^ v_q[2])
                   : ((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]));
  assign gg  = low ? (v_q[4] ^ v_q[5] ^ v_q[6]) : ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]));
  assign tt1 = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
  assign tt2 = gg + v_q[7] + ss1 + w_q[0];
  assign w_new = sm3_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 15))
               ^ sm3_pkg::rotl(w_q[3], 7) ^ w_q[10];

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sm3_pkg::B_LOAD:  if (!q_empty_i && cnt_q[3:0] == 4'd15) st_d = sm3_pkg::B_ROUND;
      sm3_pkg::B_ROUND: if (cnt_q == 6'd63) st_d = sm3_pkg::B_FOLD;
      sm3_pkg::B_FOLD:  st_d = fin_q ? sm3_pkg::B_OUT : sm3_pkg::B_LOAD;
      sm3_pkg::B_OUT:   if (out_load && cnt_q[2:0] == 3'd7) st_d = sm3_pkg::B_LOAD;
      default:          st_d = sm3_pkg::B_LOAD;
    endcase
  end

  always_comb begin
    rd_en_o  = 1'b0;
    out_load = 1'b0;
    unique case (st_q)
      sm3_pkg::B_LOAD: rd_en_o  = !q_empty_i;
      sm3_pkg::B_OUT:  out_load = !out_valid_q || pop_i;
      default: begin
        rd_en_o  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_o) w_q <= {rd_data_i.word, w_q[15:1]};
    else if (st_q == sm3_pkg::B_ROUND) w_q <= {w_new, w_q[15:1]};
    if (rd_en_o && cnt_q[3:0] == 4'd15) begin
      v_q   <= cv_q;
      t_q   <= sm3_pkg::T_LOW;
      fin_q <= rd_data_i.fin;
    end else if (st_q == sm3_pkg::B_ROUND) begin
      v_q <= {v_q[6], sm3_pkg::rotl(v_q[5], 19), v_q[4], sm3_pkg::perm0(tt2),
              v_q[2], sm3_pkg::rotl(v_q[1], 9), v_q[0], tt1};
      t_q <= (cnt_q == 6'd15) ? sm3_pkg::rotl(sm3_pkg::T_HIGH, 16) : sm3_pkg::rotl(t_q, 1);
    end
    if (out_load) begin
      out_q <= '{digest_word: cv_q[cnt_q[2:0]], word_index: cnt_q[2:0],
                 digest_last: (cnt_q[2:0] == 3'd7)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= sm3_pkg::B_LOAD;
      cnt_q       <= 6'd0;
      cv_q        <= sm3_pkg::IV;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
      unique case (st_q)
        sm3_pkg::B_LOAD: begin
          if (rd_en_o) cnt_q <= (cnt_q[3:0] == 4'd15) ? 6'd0 : cnt_q + 6'd1;
        end
        sm3_pkg::B_ROUND: cnt_q <= cnt_q + 6'd1;
        sm3_pkg::B_FOLD: begin
          cv_q  <= cv_q ^ v_q;
          cnt_q <= 6'd0;
        end
        sm3_pkg::B_OUT: begin
          if (out_load) begin
            cnt_q <= (cnt_q[2:0] == 3'd7) ? 6'd0 : cnt_q + 6'd1;
            if (cnt_q[2:0] == 3'd7) cv_q <= sm3_pkg::IV;
          end
        end
        default: cnt_q <= 6'd0;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/sm3_hash_engine_core.sv
// ---------------------------------------------------------------------------
// SM3 hash engine core
// SM3 256-bit digest of a word stream, padded and length-terminated inside.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  input    | push / full          | in_item_i  (word, valid_bytes, is_last)
//  result   | pop / empty          | out_item_o (digest_word, word_index, last)
//
// The front takes one item a cycle while the word queue has room; a last
// item blocks the input while its padding and length words are written.
// Each block is loaded word by word, then takes 64 rounds and 1 fold in the
// single round unit. The digest follows as 8 words, one word per pop.
// Reset is immediate; no clearing pass. Either side may stall freely.
`default_nettype none

module sm3_hash_engine_core #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire sm3_pkg::in_item_t  in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output sm3_pkg::out_item_t      out_item_o
);

  logic               wr_en, q_full, rd_en, q_empty;
  sm3_pkg::blk_word_t wr_data, rd_data;

  sm3_front u_front (
    .clk_i, .rst_ni,
    .push_i    (push),
    .full_o    (full),
    .item_i    (in_item_i),
    .wr_en_o   (wr_en),
    .wr_data_o (wr_data),
    .q_full_i  (q_full)
  );

  sm3_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .full_o    (q_full),
    .rd_en_i   (rd_en),
    .rd_data_o (rd_data),
    .empty_o   (q_empty)
  );

  sm3_back u_back (
    .clk_i, .rst_ni,
    .rd_data_i (rd_data),
    .q_empty_i (q_empty),
    .rd_en_o   (rd_en),
    .empty_o   (empty),
    .pop_i     (pop),
    .item_o    (out_item_o)
  );

endmodule

`default_nettype wire

FILE: src/sm3_checker.sv
// ---------------------------------------------------------------------------
// SM3 port checker
// Checks on the top-level ports of the hash engine.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sm3_hash_engine_core_defines.svh"

module sm3_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               push,
  input wire logic               full,
  input wire sm3_pkg::in_item_t  in_item_i,
  input wire logic               empty,
  input wire logic               pop,
  input wire sm3_pkg::out_item_t out_item_o
);

  `SM3_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))
  `SM3_ASSERT_NOW(a_last_idx, clk_i, rst_ni, !empty,
                  out_item_o.digest_last == (out_item_o.word_index == 3'd7))
  // a last item always leaves padding to generate
  `SM3_ASSERT_NEXT(a_pad_busy, clk_i, rst_ni, push && !full && in_item_i.is_last, full)

endmodule

bind sm3_hash_engine_core sm3_checker u_checker (
  .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o
);

`default_nettype wire

FILE: tb/sm3_hash_engine_checker.sv
// ---------------------------------------------------------------------------
// SM3 digest checker
// Watches both channels, rebuilds each expected digest from the accepted
// words and compares every digest word in order.
// ---------------------------------------------------------------------------
`default_nettype none

module sm3_hash_engine_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic               full_i,
  input  wire sm3_pkg::in_item_t  in_item_i,
  input  wire logic               empty_i,
  input  wire logic               pop_i,
  input  wire sm3_pkg::out_item_t out_item_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0][31:0]   chain_q;
  logic [31:0]        blk_words [16];
  int unsigned        fill_cnt;
  logic [63:0]        bit_len;
  sm3_pkg::out_item_t digest_fifo [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
    int unsigned s;
    s = n % 32;
    return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tc;
    for (int j = 0; j < 16; j++) w[j] = blk_words[j];
    for (int j = 16; j < 68; j++) begin
      tc = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
      w[j] = (tc ^ rol(tc, 15) ^ rol(tc, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    {h, g, f, e, d, c, b, a} = chain_q;
    for (int j = 0; j < 64; j++) begin
      tc  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(tc, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e;
      e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    chain_q = chain_q ^ {h, g, f, e, d, c, b, a};
  endtask

  task automatic absorb_word(input logic [31:0] wd);
    blk_words[fill_cnt] = wd;
    fill_cnt = (fill_cnt + 1) % 16;
    if (fill_cnt == 0) compress_blk();
  endtask

  task automatic take_item(input sm3_pkg::in_item_t it);
    int unsigned        nb;
    logic [31:0]        keep;
    sm3_pkg::out_item_t dw;
    if (!it.is_last) begin
      bit_len += 32;
      absorb_word(it.message_word);
      return;
    end
    nb = (it.valid_bytes > 4) ? 4 : it.valid_bytes;
    bit_len += 8 * nb;
    if (nb == 4) begin
      absorb_word(it.message_word);
      absorb_word(sm3_pkg::PAD_WORD);
    end else begin
      keep = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
      absorb_word((it.message_word & keep) | (sm3_pkg::PAD_WORD >> (8 * nb)));
    end
    while (fill_cnt != 14) absorb_word(32'h0);
    absorb_word(bit_len[63:32]);
    absorb_word(bit_len[31:0]);
    for (int k = 0; k < 8; k++) begin
      dw.digest_word = chain_q[k];
      dw.word_index  = 3'(k);
      dw.digest_last = (k == 7);
      digest_fifo.push_back(dw);
    end
    chain_q  = sm3_pkg::IV;
    fill_cnt = 0;
    bit_len  = '0;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] digest mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    chain_q      = sm3_pkg::IV;
    fill_cnt     = 0;
    bit_len      = '0;
  end

  always @(posedge clk_i) begin
    sm3_pkg::out_item_t want;
    if (rst_ni) begin
      if (push_i && !full_i) take_item(in_item_i);
      if (pop_i && !empty_i) begin
        if (digest_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_item_i.digest_word));
        end else begin
          want = digest_fifo.pop_front();
          if (out_item_i.digest_word !== want.digest_word)
            report_mismatch($sformatf("word %0d: got %h want %h", want.word_index,
                                      out_item_i.digest_word, want.digest_word));
          if (out_item_i.word_index !== want.word_index)
            report_mismatch($sformatf("index: got %0d want %0d",
                                      out_item_i.word_index, want.word_index));
          if (out_item_i.digest_last !== want.digest_last)
            report_mismatch($sformatf("last flag at index %0d", want.word_index));
        end
      end
    end
    pending_o <= digest_fifo.size();
  end

endmodule

`default_nettype wire

FILE: tb/tb_sm3_hash_engine_core.sv
// ---------------------------------------------------------------------------
// SM3 hash engine testbench
// Feeds directed and random messages through the word channel under varying
// stalls; the checker predicts each digest and compares the result words.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_sm3_hash_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  sm3_pkg::in_item_t  in_item;
  logic               empty;
  logic               pop;
  sm3_pkg::out_item_t out_item;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  sm3_hash_engine_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  sm3_hash_engine_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_item_i    (in_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random pop, rate set by the current phase.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Holds push high until the item is taken; idles at random between items.
  task automatic send_word(input logic [31:0] wd, input logic [2:0] nb, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{message_word: wd, valid_bytes: nb, is_last: lst};
    do @(posedge clk_i); while (full);
  endtask

  // Message of nfull whole words plus a last word with nb bytes.
  task automatic send_msg(input int nfull, input logic [2:0] nb, input int pat);
    logic [31:0] wd;
    for (int i = 0; i < nfull; i++) begin
      wd = (pat == 0) ? 32'h0 : (pat == 1) ? 32'hFFFF_FFFF : $urandom;
      send_word(wd, ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
    end
    wd = (pat == 0) ? 32'h0 : (pat == 1) ? 32'hFFFF_FFFF : $urandom;
    send_word(wd, nb, 1'b1);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0 && ++guard < 200000);
  endtask

  initial begin
    int sent;
    int nf;
    push          = 1'b0;
    pop           = 1'b0;
    in_item       = '0;
    send_idle_pct = 37;
    recv_idle_pct = 80;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, every byte count, block edges, bit extremes.
    send_msg(0, 3'd0, 2);
    send_msg(0, 3'd3, 2);   // "abc"-like short message
    send_msg(0, 3'd4, 1);
    send_msg(13, 3'd4, 2);  // pad marker lands in word 14: two blocks
    send_msg(12, 3'd7, 1);  // oversized byte count
    send_msg(14, 3'd1, 0);
    send_msg(15, 3'd2, 2);
    drain();                // sender holds off until all digests are out

    // Random phases; most messages short, a few multi-block.
    sent = 61;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 37 : 0;
      while (sent < 61 + (ph + 1) * 137) begin
        nf = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
        send_msg(nf, 3'($urandom_range(7)), ($urandom_range(15) == 0) ? 1 : 2);
        sent += nf + 1;
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
